[sv/ges_pkg.sv]
`timescale 1ns / 1ps
package ges_pkg;
	localparam int MaxSize = 16;
	localparam int IdxW = 4;
	localparam int AddrW = 8;
	localparam int LoadW = 9;
	localparam int SizeW = 5;
	localparam int ThrW = 17;
	localparam int CfgIdxW = 1;
	localparam int CfgDataW = 17;
	localparam logic [CfgIdxW-1:0] RegMatrixSize = 1'd0;
	localparam logic [CfgIdxW-1:0] RegSingularThreshold = 1'd1;
	localparam logic signed [31:0] QMax = 32'sh7fffffff;
	localparam logic signed [31:0] QMin = 32'sh80000000;

	typedef struct packed {
		logic [IdxW-1:0] solution_index;
		logic signed [31:0] solution_value;
		logic status;
		logic last_flag;
	} result_t;

	function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'(QMax);
		lo = 64'(QMin);
		if (v > hi) return QMax;
		if (v < lo) return QMin;
		return v[31:0];
	endfunction
endpackage

[sv/ges_if.sv]
`timescale 1ns / 1ps
interface ges_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] entry_value;
	modport source(output valid, output entry_value, input ready);
	modport sink(input valid, input entry_value, output ready);
endinterface

interface ges_out_if;
	logic valid;
	logic ready;
	logic [ges_pkg::IdxW-1:0] solution_index;
	logic signed [31:0] solution_value;
	logic status;
	logic last_flag;
	modport source(output valid, output solution_index, output solution_value,
		output status, output last_flag, input ready);
	modport sink(input valid, input solution_index, input solution_value,
		input status, input last_flag, output ready);
endinterface

[sv/gauss_elimination_solver.sv]
`timescale 1ns / 1ps
// gaussian elimination solver with partial pivoting, signed q16.16
// in_ch: one item per entry_value; n*n matrix entries row-major, then n rhs
// entries. the item that completes the load starts a solve; in_ch.ready is low
// until every result of that solve has been taken.
// out_ch: n items with ascending solution_index, last_flag on the last one; or
// one item with status 1 (index 0, value 0) when a pivot is too small.
// cfg: write matrix_size (index 0, clears the partial load) or
// singular_threshold (index 1) while idle.
// a single sequencer drives the multiply/subtract arithmetic and one serial
// divider over a 256-word matrix memory; loading takes one item per cycle.
// reset clears the load count, the registers to 4 and 1, and the sequencer.
// a stalled receiver holds the current result; the solve waits for it.
module gauss_elimination_solver (
	input  logic clk,
	input  logic arst_n,
	ges_in_if.sink in_ch,
	ges_out_if.source out_ch,
	input  logic cfg_we,
	input  logic [ges_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [ges_pkg::CfgDataW-1:0] cfg_data
);
	typedef enum logic [4:0] {
		LOAD, PV_RD, PV_CMP, PV_CHK, SW_RD, SW_RD2, SW_WR, SW_WR2, SW_RHS,
		EL_RD, EL_RD2, EL_DIV, EL_WAIT, EL_ROW, EL_MUL, EL_SUB, EL_RHS,
		BS_RD, BS_RD2, BS_MUL, BS_SUB, BS_DIV, BS_WAIT, EMIT, SING
	} state_t;

	state_t state_q;
	logic [ges_pkg::SizeW-1:0] size_q;
	logic [ges_pkg::ThrW-1:0] thr_q;
	logic [ges_pkg::LoadW-1:0] load_q;
	logic [ges_pkg::IdxW-1:0] row_q, col_q;
	logic [ges_pkg::IdxW:0] n_m1;
	logic [ges_pkg::IdxW:0] p_q, r_q, c_q, best_q;
	logic [32:0] best_mag_q;
	logic signed [31:0] mem_q [0:ges_pkg::MaxSize*ges_pkg::MaxSize-1];
	logic signed [31:0] rhs_q [0:ges_pkg::MaxSize-1];
	logic signed [31:0] sol_q [0:ges_pkg::MaxSize-1];
	logic signed [31:0] rd_q, a_q, f_q, s_q;
	logic signed [63:0] prod_q;
	logic [ges_pkg::AddrW-1:0] raddr;
	logic div_start;
	logic signed [31:0] div_num, div_den, div_quo;
	logic div_done;
	logic out_valid_q;
	ges_pkg::result_t res_q;
	logic [ges_pkg::IdxW:0] n_eff;
	logic [32:0] mag_rd;
	logic signed [63:0] prod_fl;

	// effective order
	always_comb begin
		if (size_q == 5'd0) n_eff = 5'd1;
		else if (size_q > 5'(ges_pkg::MaxSize)) n_eff = 5'(ges_pkg::MaxSize);
		else n_eff = size_q;
	end
	assign n_m1 = n_eff - 5'd1;
	assign mag_rd = rd_q[31] ? 33'(-{rd_q[31], rd_q}) : {1'b0, rd_q};
	assign prod_fl = prod_q >>> 16;

	assign in_ch.ready = (state_q == LOAD);
	assign out_ch.valid = out_valid_q;
	assign out_ch.solution_index = res_q.solution_index;
	assign out_ch.solution_value = res_q.solution_value;
	assign out_ch.status = res_q.status;
	assign out_ch.last_flag = res_q.last_flag;

	// memory read address per state
	always_comb begin
		unique case (state_q)
			PV_RD, PV_CMP: raddr = {r_q[3:0], p_q[3:0]};
			SW_RD: raddr = {p_q[3:0], c_q[3:0]};
			SW_RD2: raddr = {best_q[3:0], c_q[3:0]};
			EL_RD: raddr = {r_q[3:0], p_q[3:0]};
			EL_RD2, EL_DIV: raddr = {p_q[3:0], p_q[3:0]};
			EL_ROW: raddr = {p_q[3:0], c_q[3:0]};
			EL_MUL: raddr = {r_q[3:0], c_q[3:0]};
			BS_RD: raddr = {r_q[3:0], c_q[3:0]};
			BS_DIV, BS_RD2: raddr = {r_q[3:0], r_q[3:0]};
			default: raddr = {r_q[3:0], c_q[3:0]};
		endcase
	end

	assign div_start = (state_q == EL_DIV) || (state_q == BS_DIV);
	assign div_num = (state_q == EL_DIV) ? a_q : s_q;
	assign div_den = rd_q;

	ges_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quo(div_quo)
	);

	// matrix memory read
	always_ff @(posedge clk) begin
		rd_q <= mem_q[raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LOAD;
			size_q <= 5'd4;
			thr_q <= 17'd1;
			load_q <= '0;
			row_q <= '0;
			col_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == ges_pkg::RegMatrixSize) begin
					size_q <= cfg_data[ges_pkg::SizeW-1:0];
					load_q <= '0;
				end else if (cfg_index == ges_pkg::RegSingularThreshold) begin
					thr_q <= cfg_data[ges_pkg::ThrW-1:0];
				end
			end
			unique case (state_q)
				LOAD: begin
					if (in_ch.valid) begin
						if ({1'b0, load_q} < 10'(n_eff) * 10'(n_eff)) begin
							mem_q[{row_q, col_q}] <= in_ch.entry_value;
							if (col_q == n_m1[3:0]) begin
								col_q <= '0;
								row_q <= (row_q == n_m1[3:0]) ? '0 : row_q + 4'd1;
							end else begin
								col_q <= col_q + 4'd1;
							end
							load_q <= load_q + 9'd1;
						end else begin
							rhs_q[col_q] <= in_ch.entry_value;
							if (col_q == n_m1[3:0]) begin
								col_q <= '0;
								load_q <= '0;
								p_q <= '0;
								r_q <= '0;
								best_q <= '0;
								best_mag_q <= '0;
								state_q <= PV_RD;
							end else begin
								col_q <= col_q + 4'd1;
								load_q <= load_q + 9'd1;
							end
						end
					end
				end
				// pivot search: r runs p..n-1
				PV_RD: state_q <= PV_CMP;
				PV_CMP: begin
					if (r_q == p_q || mag_rd > best_mag_q) begin
						best_mag_q <= mag_rd;
						best_q <= r_q;
					end
					if (r_q == n_m1) begin
						state_q <= PV_CHK;
					end else begin
						r_q <= r_q + 5'd1;
						state_q <= PV_RD;
					end
				end
				PV_CHK: begin
					if (best_mag_q == 33'd0 || best_mag_q < {16'd0, thr_q}) begin
						state_q <= SING;
					end else if (best_q != p_q) begin
						c_q <= '0;
						state_q <= SW_RD;
					end else begin
						r_q <= p_q + 5'd1;
						state_q <= (p_q == n_m1) ? BS_RD2 : EL_RD;
						if (p_q == n_m1) begin
							r_q <= n_m1;
							c_q <= n_eff;
							s_q <= rhs_q[n_m1[3:0]];
						end
					end
				end
				// row swap p <-> best, one memory write per cycle
				SW_RD: state_q <= SW_RD2;
				SW_RD2: begin
					a_q <= rd_q;
					state_q <= SW_WR;
				end
				SW_WR: begin
					mem_q[{p_q[3:0], c_q[3:0]}] <= rd_q;
					state_q <= SW_WR2;
				end
				SW_WR2: begin
					mem_q[{best_q[3:0], c_q[3:0]}] <= a_q;
					if (c_q == n_m1) begin
						state_q <= SW_RHS;
					end else begin
						c_q <= c_q + 5'd1;
						state_q <= SW_RD;
					end
				end
				SW_RHS: begin
					rhs_q[p_q[3:0]] <= rhs_q[best_q[3:0]];
					rhs_q[best_q[3:0]] <= rhs_q[p_q[3:0]];
					r_q <= p_q + 5'd1;
					if (p_q == n_m1) begin
						r_q <= n_m1;
						c_q <= n_eff;
						s_q <= rhs_q[best_q[3:0]];
						state_q <= BS_RD2;
					end else begin
						state_q <= EL_RD;
					end
				end
				// elimination of row r: factor, then row and rhs update
				EL_RD: state_q <= EL_RD2;
				EL_RD2: begin
					a_q <= rd_q;
					state_q <= EL_DIV;
				end
				EL_DIV: state_q <= EL_WAIT;
				EL_WAIT: begin
					if (div_done) begin
						f_q <= div_quo;
						c_q <= p_q;
						if (div_quo == 32'sd0) begin
							if (r_q == n_m1) begin
								p_q <= p_q + 5'd1;
								r_q <= p_q + 5'd1;
								state_q <= PV_RD;
							end else begin
								r_q <= r_q + 5'd1;
								state_q <= EL_RD;
							end
						end else begin
							state_q <= EL_ROW;
						end
					end
				end
				EL_ROW: state_q <= EL_MUL;
				EL_MUL: begin
					prod_q <= 64'(f_q) * 64'(rd_q);
					state_q <= EL_SUB;
				end
				EL_SUB: begin
					mem_q[{r_q[3:0], c_q[3:0]}] <= ges_pkg::sat64(64'(rd_q)
						- 64'(ges_pkg::sat64(prod_fl)));
					if (c_q == n_m1) begin
						prod_q <= 64'(f_q) * 64'(rhs_q[p_q[3:0]]);
						state_q <= EL_RHS;
					end else begin
						c_q <= c_q + 5'd1;
						state_q <= EL_ROW;
					end
				end
				EL_RHS: begin
					rhs_q[r_q[3:0]] <= ges_pkg::sat64(64'(rhs_q[r_q[3:0]])
						- 64'(ges_pkg::sat64(prod_fl)));
					if (r_q == n_m1) begin
						p_q <= p_q + 5'd1;
						r_q <= p_q + 5'd1;
						state_q <= PV_RD;
					end else begin
						r_q <= r_q + 5'd1;
						state_q <= EL_RD;
					end
				end
				// back substitution, row r, columns c..n-1
				BS_RD2: begin
					if (c_q == n_eff) begin
						state_q <= BS_DIV;
					end else begin
						state_q <= BS_RD;
					end
				end
				BS_RD: state_q <= BS_MUL;
				BS_MUL: begin
					prod_q <= 64'(rd_q) * 64'(sol_q[c_q[3:0]]);
					state_q <= BS_SUB;
				end
				BS_SUB: begin
					s_q <= ges_pkg::sat64(64'(s_q) - 64'(ges_pkg::sat64(prod_fl)));
					c_q <= c_q + 5'd1;
					state_q <= BS_RD2;
				end
				BS_DIV: state_q <= BS_WAIT;
				BS_WAIT: begin
					if (div_done) begin
						sol_q[r_q[3:0]] <= div_quo;
						if (r_q == 5'd0) begin
							c_q <= '0;
							state_q <= EMIT;
						end else begin
							r_q <= r_q - 5'd1;
							c_q <= r_q;
							s_q <= rhs_q[r_q[3:0] - 4'd1];
							state_q <= BS_RD2;
						end
					end
				end
				// results out
				EMIT: begin
					if (!out_valid_q || out_ch.ready) begin
						if (out_valid_q && res_q.last_flag) begin
							out_valid_q <= 1'b0;
							c_q <= '0;
							row_q <= '0;
							col_q <= '0;
							state_q <= LOAD;
						end else begin
							out_valid_q <= 1'b1;
							res_q.solution_index <= c_q[3:0];
							res_q.solution_value <= sol_q[c_q[3:0]];
							res_q.status <= 1'b0;
							res_q.last_flag <= (c_q == n_m1);
							c_q <= c_q + 5'd1;
						end
					end
				end
				SING: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						res_q <= '{solution_index: '0, solution_value: '0,
							status: 1'b1, last_flag: 1'b1};
					end else if (out_ch.ready) begin
						out_valid_q <= 1'b0;
						row_q <= '0;
						col_q <= '0;
						state_q <= LOAD;
					end
				end
				default: state_q <= LOAD;
			endcase
			if (state_q == LOAD && cfg_we && cfg_index == ges_pkg::RegMatrixSize) begin
				row_q <= '0;
				col_q <= '0;
			end
		end
	end
endmodule

[sv/ges_divider.sv]
`timescale 1ns / 1ps
// restoring divider: (a << 16) / b, truncate toward zero, saturate; one quotient bit a cycle
module ges_divider (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic done,
	output logic signed [31:0] quo
);
	logic busy_q;
	logic [5:0] cnt_q;
	logic [47:0] dvd_q;
	logic [31:0] dvs_q;
	logic [48:0] quo_q;
	logic [32:0] rem_q;
	logic neg_q;
	logic zero_q;
	logic num_pos_q;
	logic num_zero_q;
	logic [32:0] rem_sh;
	logic [47:0] abs_num;
	logic [31:0] abs_den;
	logic signed [63:0] sq;

	assign abs_num = {16'd0, (num[31] ? 32'(-num) : 32'(num))} << 16;
	assign abs_den = den[31] ? 32'(-den) : 32'(den);
	assign rem_sh = {rem_q[31:0], dvd_q[47]};

	// signed, saturated quotient
	always_comb begin
		sq = neg_q ? -$signed({15'd0, quo_q}) : $signed({15'd0, quo_q});
		if (zero_q) begin
			quo = num_zero_q ? 32'sd0 : (num_pos_q ? ges_pkg::QMax : ges_pkg::QMin);
		end else begin
			quo = ges_pkg::sat64(sq);
		end
	end

	// iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd48;
				dvd_q <= abs_num;
				dvs_q <= abs_den;
				quo_q <= '0;
				rem_q <= '0;
				neg_q <= num[31] ^ den[31];
				zero_q <= (den == 32'sd0);
				num_pos_q <= !num[31] && num != 32'sd0;
				num_zero_q <= (num == 32'sd0);
			end else if (busy_q) begin
				dvd_q <= dvd_q << 1;
				if (rem_sh >= {1'b0, dvs_q}) begin
					rem_q <= rem_sh - {1'b0, dvs_q};
					quo_q <= {quo_q[47:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[47:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

[sv/ges_checker.sv]
`timescale 1ns / 1ps
module ges_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic status,
	input logic last_flag,
	input logic [ges_pkg::IdxW-1:0] solution_index,
	input logic signed [31:0] solution_value
);
	// no input taken while a result is shown
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input ready during output");
	// singular item is index 0, value 0, last
	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> last_flag && solution_index == '0 && solution_value == '0)
		else $error("bad singular item");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(solution_value))
		else $error("result dropped");
	// after the last result the block returns to loading
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_flag |=> !out_valid)
		else $error("extra result");
endmodule

bind gauss_elimination_solver ges_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(out_ch.status),
	.last_flag(out_ch.last_flag), .solution_index(out_ch.solution_index),
	.solution_value(out_ch.solution_value)
);
